// File: rtl/sprite_animation_frame_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Sprite animation frame sequencer - assertion macros
// Immediate-cycle and next-cycle implication checks, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_ANIMATION_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// check that cons holds in the cycle where ante holds
`define SFSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante holds
`define SFSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfsu_pkg.sv
// ----------------------------------------------------------------------------
// sfsu_pkg
// Shared widths, codes, controller states and control structs.
// ----------------------------------------------------------------------------
package sfsu_pkg;

  localparam int MODE_W      = 4;
  localparam int FRM_IN_W    = 9;
  localparam int TICK_W      = 8;
  localparam int ELAPSED_W   = 8;
  localparam int START_W     = 17;
  localparam int CNT_W       = 18;
  localparam int SUM_W       = 19;
  localparam int BASE_W      = 10;
  localparam int PERIOD_W    = 18;
  localparam int FIDX_W      = 8;
  localparam int PCT_W       = 7;
  localparam int PCT_NUM_W   = 15;
  localparam int DIV_NW      = SUM_W;
  localparam int DIV_DW      = PERIOD_W;
  localparam int DIV_CW      = $clog2(DIV_NW + 1);
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_AW-1:0] CFG_ANIM_MODE       = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_COUNT     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TICKS_PER_FRAME = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ONESHOT          = 4'd2;
  localparam logic [MODE_W-1:0] MODE_PINGPONG         = 4'd3;
  localparam logic [MODE_W-1:0] MODE_PP_ONESHOT       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BLEND            = 4'd5;
  localparam logic [MODE_W-1:0] MODE_BLEND_ONESHOT    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_BLEND_PP         = 4'd7;
  localparam logic [MODE_W-1:0] MODE_BLEND_PP_ONESHOT = 4'd8;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_RUN,
    ST_FRM_GO,
    ST_FRM_RUN,
    ST_PCT_GO,
    ST_PCT_RUN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_MOD,
    DIV_FRAME,
    DIV_PCT
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic restart;
    logic div_busy;
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/sfsu_div.sv
// ----------------------------------------------------------------------------
// sfsu_div
// Restoring divider, one quotient bit per cycle, operands latched on start.
// ----------------------------------------------------------------------------
module sfsu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sfsu_pkg::DIV_NW-1:0] dividend,
  input  logic [sfsu_pkg::DIV_DW-1:0] divisor,
  output logic [sfsu_pkg::DIV_NW-1:0] quo,
  output logic [sfsu_pkg::DIV_DW-1:0] rem,
  output logic                        busy,
  output logic                        done
);

  logic [sfsu_pkg::DIV_DW-1:0] rem_r, rem_nxt;
  logic [sfsu_pkg::DIV_NW-1:0] quo_r, quo_nxt;
  logic [sfsu_pkg::DIV_DW-1:0] dvs_r;
  logic [sfsu_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [sfsu_pkg::DIV_DW:0]   trial;
  logic                        qbit;

  always_comb begin
    trial    = {rem_r, quo_r[sfsu_pkg::DIV_NW-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    rem_nxt  = qbit ? sfsu_pkg::DIV_DW'(trial - {1'b0, dvs_r})
                    : trial[sfsu_pkg::DIV_DW-1:0];
    quo_nxt  = {quo_r[sfsu_pkg::DIV_NW-2:0], qbit};
    cnt_nxt  = cnt_r - sfsu_pkg::DIV_CW'(1);
    busy_nxt = busy_r && (cnt_r != sfsu_pkg::DIV_CW'(1));
    done_nxt = busy_r && (cnt_r == sfsu_pkg::DIV_CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= sfsu_pkg::DIV_CW'(sfsu_pkg::DIV_NW);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// File: rtl/sfsu_dp.sv
// ----------------------------------------------------------------------------
// sfsu_dp
// Datapath: config registers, tick counter, period, shared divider, result.
// ----------------------------------------------------------------------------
module sfsu_dp #(
  parameter int MAX_FRAMES          = 256,
  parameter int MAX_TICKS_PER_FRAME = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfsu_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [sfsu_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic [sfsu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  sfsu_pkg::ctrl_cmd_t              cmd,
  output sfsu_pkg::dp_sts_t                sts,
  output logic [sfsu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int FR_LIM = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
  localparam int TK_LIM = (MAX_TICKS_PER_FRAME < 255) ? MAX_TICKS_PER_FRAME : 255;
  localparam logic [sfsu_pkg::FRM_IN_W-1:0] FR_LIM_V = sfsu_pkg::FRM_IN_W'(FR_LIM);
  localparam logic [sfsu_pkg::TICK_W-1:0]   TK_LIM_V = sfsu_pkg::TICK_W'(TK_LIM);

  logic [sfsu_pkg::MODE_W-1:0]   mode_r;
  logic [sfsu_pkg::FRM_IN_W-1:0] frames_r;
  logic [sfsu_pkg::TICK_W-1:0]   ticks_r;

  logic [sfsu_pkg::CNT_W-1:0]    counter_r;
  logic [sfsu_pkg::SUM_W-1:0]    sum_r;
  logic [sfsu_pkg::PERIOD_W-1:0] period_r;
  logic                          restart_r;
  logic                          end_r;
  logic [sfsu_pkg::BASE_W-1:0]   fa_r;
  logic [sfsu_pkg::TICK_W-1:0]   rem_r;
  logic [sfsu_pkg::PCT_W-1:0]    pct_r;

  logic [sfsu_pkg::FIDX_W-1:0]   fa_out_r, fb_out_r;
  logic [sfsu_pkg::PCT_W-1:0]    pct_out_r;
  logic                          end_out_r;

  logic [sfsu_pkg::ELAPSED_W-1:0] in_elapsed;
  logic [sfsu_pkg::START_W-1:0]   in_start;

  logic [sfsu_pkg::FRM_IN_W-1:0] frames_eff;
  logic [sfsu_pkg::TICK_W-1:0]   spd;
  logic                          pingpong, oneshot, blend;
  logic [sfsu_pkg::BASE_W-1:0]   pp_top, base, lim;
  logic [sfsu_pkg::PERIOD_W-1:0] period_calc;
  logic [sfsu_pkg::TICK_W-1:0]   pct_diff;
  logic [sfsu_pkg::PCT_NUM_W-1:0] pct_num;

  logic [sfsu_pkg::DIV_NW-1:0]   div_dvd, div_quo;
  logic [sfsu_pkg::DIV_DW-1:0]   div_dvs, div_rem;
  logic                          div_busy, div_done;
  logic                          end_hit;

  logic [sfsu_pkg::BASE_W-1:0]   fa_c, fb_c, fa_rf, fb_rf;
  logic [sfsu_pkg::PCT_W-1:0]    pct_c;

  function automatic logic [sfsu_pkg::BASE_W-1:0] reflect_idx(
    input logic [sfsu_pkg::BASE_W-1:0]   idx,
    input logic [sfsu_pkg::BASE_W-1:0]   top,
    input logic [sfsu_pkg::FRM_IN_W-1:0] fr
  );
    logic [sfsu_pkg::BASE_W-1:0] res;
    res = idx;
    if (idx >= {1'b0, fr}) begin
      res = (idx > top) ? '0 : top - idx;
    end
    return res;
  endfunction

  assign in_elapsed = in_tdata[sfsu_pkg::ELAPSED_W-1:0];
  assign in_start   = in_tdata[sfsu_pkg::ELAPSED_W +: sfsu_pkg::START_W];

  always_comb begin
    frames_eff = frames_r;
    if (frames_r == '0) begin
      frames_eff = sfsu_pkg::FRM_IN_W'(1);
    end else if (frames_r > FR_LIM_V) begin
      frames_eff = FR_LIM_V;
    end
    spd = ticks_r;
    if (ticks_r == '0) begin
      spd = sfsu_pkg::TICK_W'(1);
    end else if (ticks_r > TK_LIM_V) begin
      spd = TK_LIM_V;
    end
    pingpong = (mode_r == sfsu_pkg::MODE_PINGPONG) || (mode_r == sfsu_pkg::MODE_PP_ONESHOT) ||
               (mode_r == sfsu_pkg::MODE_BLEND_PP) ||
               (mode_r == sfsu_pkg::MODE_BLEND_PP_ONESHOT);
    oneshot  = (mode_r == sfsu_pkg::MODE_ONESHOT) || (mode_r == sfsu_pkg::MODE_PP_ONESHOT) ||
               (mode_r == sfsu_pkg::MODE_BLEND_ONESHOT) ||
               (mode_r == sfsu_pkg::MODE_BLEND_PP_ONESHOT);
    blend    = (mode_r >= sfsu_pkg::MODE_BLEND);
    pp_top   = {frames_eff - sfsu_pkg::FRM_IN_W'(1), 1'b0};
    if (pingpong) begin
      base = (pp_top == '0) ? sfsu_pkg::BASE_W'(1) : pp_top;
    end else begin
      base = sfsu_pkg::BASE_W'(frames_eff);
    end
    lim = pingpong ? base : base - sfsu_pkg::BASE_W'(1);
    period_calc = sfsu_pkg::PERIOD_W'(base) * sfsu_pkg::PERIOD_W'(spd);
    pct_diff = spd - rem_r;
    pct_num  = sfsu_pkg::PCT_NUM_W'(pct_diff) * sfsu_pkg::PCT_NUM_W'(sfsu_pkg::PCT_FULL);
  end

  always_comb begin
    case (cmd.div_sel)
      sfsu_pkg::DIV_MOD: begin
        div_dvd = sum_r;
        div_dvs = period_r;
      end
      sfsu_pkg::DIV_FRAME: begin
        div_dvd = sfsu_pkg::DIV_NW'(counter_r);
        div_dvs = sfsu_pkg::DIV_DW'(spd);
      end
      sfsu_pkg::DIV_PCT: begin
        div_dvd = sfsu_pkg::DIV_NW'(pct_num);
        div_dvs = sfsu_pkg::DIV_DW'(spd);
      end
      default: begin
        div_dvd = sum_r;
        div_dvs = period_r;
      end
    endcase
  end

  sfsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (div_quo),
    .rem      (div_rem),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign sts     = '{restart: in_tuser, div_busy: div_busy, div_done: div_done};
  assign end_hit = (sum_r >= sfsu_pkg::SUM_W'(period_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      frames_r <= sfsu_pkg::FRM_IN_W'(1);
      ticks_r  <= sfsu_pkg::TICK_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        sfsu_pkg::CFG_ANIM_MODE:       mode_r   <= cfg_wdata[sfsu_pkg::MODE_W-1:0];
        sfsu_pkg::CFG_FRAME_COUNT:     frames_r <= cfg_wdata[sfsu_pkg::FRM_IN_W-1:0];
        sfsu_pkg::CFG_TICKS_PER_FRAME: ticks_r  <= cfg_wdata[sfsu_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (cmd.load && in_tuser) begin
      counter_r <= sfsu_pkg::CNT_W'(in_start);
    end else if (cmd.cap && (cmd.div_sel == sfsu_pkg::DIV_MOD)) begin
      if (oneshot) begin
        counter_r <= end_hit ? period_r : sum_r[sfsu_pkg::CNT_W-1:0];
      end else begin
        counter_r <= div_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      restart_r <= in_tuser;
      sum_r     <= sfsu_pkg::SUM_W'(counter_r) + sfsu_pkg::SUM_W'(in_elapsed);
      period_r  <= period_calc;
    end
    if (cmd.cap) begin
      case (cmd.div_sel)
        sfsu_pkg::DIV_MOD:   end_r <= end_hit;
        sfsu_pkg::DIV_FRAME: begin
          fa_r  <= div_quo[sfsu_pkg::BASE_W-1:0];
          rem_r <= div_rem[sfsu_pkg::TICK_W-1:0];
        end
        sfsu_pkg::DIV_PCT:   pct_r <= div_quo[sfsu_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fa_c = fa_r;
    fb_c = fa_r + sfsu_pkg::BASE_W'(1);
    if (oneshot) begin
      if (fa_c >= base) begin
        fa_c = lim;
      end
      if (fb_c >= base) begin
        fb_c = lim;
      end
    end
    if (fb_c == base) begin
      fb_c = '0;
    end
    fa_rf = pingpong ? reflect_idx(fa_c, pp_top, frames_eff) : fa_c;
    fb_rf = pingpong ? reflect_idx(fb_c, pp_top, frames_eff) : fb_c;
    pct_c = blend ? pct_r : sfsu_pkg::PCT_FULL;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (restart_r) begin
        fa_out_r  <= '0;
        fb_out_r  <= '0;
        pct_out_r <= sfsu_pkg::PCT_FULL;
        end_out_r <= 1'b0;
      end else begin
        fa_out_r  <= fa_rf[sfsu_pkg::FIDX_W-1:0];
        fb_out_r  <= fb_rf[sfsu_pkg::FIDX_W-1:0];
        pct_out_r <= pct_c;
        end_out_r <= end_r;
      end
    end
  end

  assign out_tdata = {1'b0, pct_out_r, fb_out_r, fa_out_r};
  assign out_tlast = end_out_r;

endmodule

// File: rtl/sfsu_ctrl.sv
// ----------------------------------------------------------------------------
// sfsu_ctrl
// Controller: sequences load, three divider passes (skipped for a restart beat) and the result beat.
// ----------------------------------------------------------------------------
module sfsu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sfsu_pkg::dp_sts_t   sts,
  output sfsu_pkg::ctrl_cmd_t cmd
);

  sfsu_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfsu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = sfsu_pkg::DIV_MOD;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      sfsu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.restart ? sfsu_pkg::ST_EMIT : sfsu_pkg::ST_MOD_GO;
        end
      end
      sfsu_pkg::ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = sfsu_pkg::ST_MOD_RUN;
      end
      sfsu_pkg::ST_MOD_RUN: begin
        if (sts.div_done) begin
          cmd.cap   = 1'b1;
          state_nxt = sfsu_pkg::ST_FRM_GO;
        end
      end
      sfsu_pkg::ST_FRM_GO: begin
        cmd.div_sel   = sfsu_pkg::DIV_FRAME;
        cmd.div_start = 1'b1;
        state_nxt     = sfsu_pkg::ST_FRM_RUN;
      end
      sfsu_pkg::ST_FRM_RUN: begin
        cmd.div_sel = sfsu_pkg::DIV_FRAME;
        if (sts.div_done) begin
          cmd.cap   = 1'b1;
          state_nxt = sfsu_pkg::ST_PCT_GO;
        end
      end
      sfsu_pkg::ST_PCT_GO: begin
        cmd.div_sel   = sfsu_pkg::DIV_PCT;
        cmd.div_start = 1'b1;
        state_nxt     = sfsu_pkg::ST_PCT_RUN;
      end
      sfsu_pkg::ST_PCT_RUN: begin
        cmd.div_sel = sfsu_pkg::DIV_PCT;
        if (sts.div_done) begin
          cmd.cap   = 1'b1;
          state_nxt = sfsu_pkg::ST_EMIT;
        end
      end
      sfsu_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sfsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfsu_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == sfsu_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/sprite_animation_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Sprite animation frame sequencer - top level
// Advance beat: the result follows three passes of the shared one-bit-per-cycle divider
// (modulo, frame index, blend percent); the next beat is taken after the result is loaded.
// Restart beat: the divider passes are skipped. Either result loads once the output is free.
// Sync active-low reset: idle, counter 0, mode 0, frame count 1, ticks per
// frame 1, no result pending.
// ----------------------------------------------------------------------------
`include "sprite_animation_frame_sequencer_unit_defines.svh"

module sprite_animation_frame_sequencer_unit #(
  parameter int MAX_FRAMES          = 256,
  parameter int MAX_TICKS_PER_FRAME = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfsu_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [sfsu_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sfsu_pkg::IN_TDATA_W-1:0]  in_tdata,   // elapsed_ticks[7:0], start_count[24:8]
  input  logic                             in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sfsu_pkg::OUT_TDATA_W-1:0] out_tdata,  // frame_a[7:0], frame_b[15:8],
                                                       // blend_percent[22:16]
  output logic                             out_tlast   // loop_end
);

  sfsu_pkg::ctrl_cmd_t cmd;
  sfsu_pkg::dp_sts_t   sts;

  sfsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sfsu_dp #(
    .MAX_FRAMES          (MAX_FRAMES),
    .MAX_TICKS_PER_FRAME (MAX_TICKS_PER_FRAME)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

`SFSU_ASSERT_NOW(a_ready_div_idle, in_tready, !sts.div_busy, "input ready while divider busy")
`SFSU_ASSERT_NOW(a_start_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
`SFSU_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second beat taken in flight")
`SFSU_ASSERT_NOW(a_pct_range, out_tvalid, out_tdata[22:16] <= 7'd100, "blend percent above 100")

endmodule

// File: verif/sfsu_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfsu_tb_pkg
// Command and mode codes shared by the sequencer testbench and its checker.
// ----------------------------------------------------------------------------
package sfsu_tb_pkg;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [3:0] MODE_LOOP      = 4'd0;
  localparam logic [3:0] MODE_LOOP_ALT  = 4'd1;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

endpackage

// File: verif/frame_sequence_checker.sv
// ----------------------------------------------------------------------------
// Sprite animation frame sequencer - result checker
// Tracks register writes and accepted input beats, predicts the frame pair,
// blend weight and loop-end flag of each beat, and compares every result
// beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_sequence_checker
  import sfsu_pkg::*;
  import sfsu_tb_pkg::*;
#(
  parameter int MAX_FRAMES          = 256,
  parameter int MAX_TICKS_PER_FRAME = 255
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // elapsed_ticks, start_count
  input  logic                   in_tuser,   // command
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // frame_a, frame_b, blend_percent
  input  logic                   out_tlast,  // loop_end
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FIDX_W-1:0] frame_a;
    logic [FIDX_W-1:0] frame_b;
    logic [PCT_W-1:0]  pct;
    logic              loop_end;
  } frame_beat_t;

  logic [MODE_W-1:0]   mode_r;
  logic [FRM_IN_W-1:0] frames_r;
  logic [TICK_W-1:0]   ticks_r;
  int unsigned         count_r;
  frame_beat_t         expected_frames[$];
  int                  mismatches;

  function automatic int unsigned fold_index(input int unsigned idx,
                                             input int unsigned frames);
    int unsigned top;
    top = (frames - 1) * 2;
    if (idx < frames) return idx;
    else if (idx > top) return 0;
    else return top - idx;
  endfunction

  function automatic frame_beat_t predict_frames(input logic restart,
                                                 input logic [ELAPSED_W-1:0] elapsed,
                                                 input logic [START_W-1:0] start,
                                                 output int unsigned count_next);
    frame_beat_t beat;
    int unsigned frames, spd, base, period, cnt, fa, fb, lim, pct;
    logic        pp, os, wrapped;
    if (restart) begin
      beat       = '{frame_a: '0, frame_b: '0, pct: PCT_FULL, loop_end: 1'b0};
      count_next = 32'(start);
      return beat;
    end
    frames = 32'(frames_r);
    if (frames < 1) frames = 1;
    if (frames > MAX_FRAMES) frames = MAX_FRAMES;
    spd = 32'(ticks_r);
    if (spd < 1) spd = 1;
    if (spd > MAX_TICKS_PER_FRAME) spd = MAX_TICKS_PER_FRAME;
    pp = mode_r inside {MODE_PINGPONG, MODE_PP_ONESHOT, MODE_BLEND_PP, MODE_BLEND_PP_ONESHOT};
    os = mode_r inside {MODE_ONESHOT, MODE_PP_ONESHOT, MODE_BLEND_ONESHOT,
                        MODE_BLEND_PP_ONESHOT};
    base = frames;
    if (pp) begin
      base = (frames - 1) * 2;
      if (base < 1) base = 1;
    end
    period  = base * spd;
    cnt     = count_r + 32'(elapsed);
    wrapped = (cnt >= period);
    if (os) begin
      if (wrapped) cnt = period;
    end else begin
      cnt = cnt % period;
    end
    fa = cnt / spd;
    fb = fa + 1;
    if (os) begin
      lim = pp ? base : base - 1;
      if (fa >= base) fa = lim;
      if (fb >= base) fb = lim;
    end
    fb = fb % base;
    if (pp) begin
      fa = fold_index(fa, frames);
      fb = fold_index(fb, frames);
    end
    pct = 32'(PCT_FULL);
    if (mode_r >= MODE_BLEND) pct = (32'(PCT_FULL) * (spd - (cnt % spd))) / spd;
    beat.frame_a  = FIDX_W'(fa);
    beat.frame_b  = FIDX_W'(fb);
    beat.pct      = PCT_W'(pct);
    beat.loop_end = wrapped;
    count_next    = cnt;
    return beat;
  endfunction

  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    int unsigned cnt_next;
    if (!rst_n) begin
      mode_r     = MODE_LOOP;
      frames_r   = FRM_IN_W'(1);
      ticks_r    = TICK_W'(1);
      count_r    = 0;
      mismatches = 0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ANIM_MODE:       mode_r = cfg_wdata[MODE_W-1:0];
          CFG_FRAME_COUNT:     frames_r = cfg_wdata[FRM_IN_W-1:0];
          CFG_TICKS_PER_FRAME: ticks_r = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.frame_a  = out_tdata[FIDX_W-1:0];
        got.frame_b  = out_tdata[2*FIDX_W-1:FIDX_W];
        got.pct      = out_tdata[2*FIDX_W+PCT_W-1:2*FIDX_W];
        got.loop_end = out_tlast;
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat a=%0d b=%0d pct=%0d end=%0b",
                     $realtime, got.frame_a, got.frame_b, got.pct, got.loop_end);
        end else begin
          want = expected_frames.pop_front();
          if (got.frame_a !== want.frame_a || got.frame_b !== want.frame_b ||
              got.pct !== want.pct || got.loop_end !== want.loop_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp a=%0d b=%0d p=%0d e=%0b got a=%0d b=%0d p=%0d e=%0b",
                       $realtime, want.frame_a, want.frame_b, want.pct, want.loop_end,
                       got.frame_a, got.frame_b, got.pct, got.loop_end);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_frames(in_tuser, in_tdata[ELAPSED_W-1:0],
                              in_tdata[ELAPSED_W+START_W-1:ELAPSED_W], cnt_next);
        count_r = cnt_next;
        expected_frames.push_back(want);
      end
    end
    pending    <= expected_frames.size();
    fail_count <= mismatches;
  end

endmodule

// File: verif/tb_sprite_animation_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Sprite animation frame sequencer - testbench top
// Directed beats on register and field extremes and every mode, then random
// phases of advance and restart beats under varied settings, with random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_sprite_animation_frame_sequencer_unit;
  import sfsu_pkg::*;
  import sfsu_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES          = 256;
  localparam int MAX_TICKS_PER_FRAME = 255;
  localparam int PHASES              = 25;
  localparam int PHASE_BEATS         = 70;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_DW-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  int                     fail_count;
  int                     pending;
  logic                   in_burst;
  logic                   out_burst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sprite_animation_frame_sequencer_unit #(
    .MAX_FRAMES          (MAX_FRAMES),
    .MAX_TICKS_PER_FRAME (MAX_TICKS_PER_FRAME)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  frame_sequence_checker #(
    .MAX_FRAMES          (MAX_FRAMES),
    .MAX_TICKS_PER_FRAME (MAX_TICKS_PER_FRAME)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_beat(input logic cmd, input logic [ELAPSED_W-1:0] elapsed,
                           input logic [START_W-1:0] start);
    int gap;
    gap = in_burst ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'({start, elapsed});
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off input until every predicted result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [FRM_IN_W-1:0] frames,
                              input logic [TICK_W-1:0] ticks);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ANIM_MODE;
    cfg_wdata <= CFG_DW'(mode);
    @(posedge clk);
    cfg_addr  <= CFG_FRAME_COUNT;
    cfg_wdata <= CFG_DW'(frames);
    @(posedge clk);
    cfg_addr  <= CFG_TICKS_PER_FRAME;
    cfg_wdata <= CFG_DW'(ticks);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int gap;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = out_burst ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_tvalid);
        end
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [MODE_W-1:0]    mode_list[4];
    logic [MODE_W-1:0]    mode;
    logic [FRM_IN_W-1:0]  frames;
    logic [TICK_W-1:0]    ticks;
    logic [ELAPSED_W-1:0] elapsed;
    logic [START_W-1:0]   start;
    int                   r;
    mode_list = '{MODE_ONESHOT, MODE_PINGPONG, MODE_BLEND_ONESHOT, MODE_BLEND_PP};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_ADVANCE;
    in_tdata  = '0;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_ADVANCE, 8'd0, '1);
    apply_config(MODE_BLEND_PP_ONESHOT, 9'd256, 8'd255);
    send_beat(CMD_RESTART, 8'd255, 17'd131071);
    send_beat(CMD_ADVANCE, 8'd255, 17'd0);
    send_beat(CMD_ADVANCE, 8'd0, 17'd0);
    apply_config(MODE_LOOP_ALT, 9'd256, 8'd255);
    send_beat(CMD_RESTART, 8'd0, 17'd131071);
    send_beat(CMD_ADVANCE, 8'd255, 17'd0);
    send_beat(CMD_ADVANCE, 8'd0, 17'd0);
    apply_config(MODE_PP_ONESHOT, 9'd1, 8'd0);
    send_beat(CMD_ADVANCE, 8'd255, 17'd0);
    send_beat(CMD_ADVANCE, 8'd1, 17'd0);
    apply_config(MODE_BLEND, 9'd0, 8'd3);
    send_beat(CMD_ADVANCE, 8'd7, 17'd0);
    send_beat(CMD_ADVANCE, 8'd255, 17'd0);
    apply_config(MODE_UNUSED_HI, 9'd511, 8'd200);
    send_beat(CMD_RESTART, 8'd0, 17'd0);
    send_beat(CMD_ADVANCE, 8'd255, 17'd0);
    send_beat(CMD_ADVANCE, 8'd128, 17'd0);
    apply_config(MODE_UNUSED_LO, 9'd300, 8'd1);
    send_beat(CMD_ADVANCE, 8'd200, 17'd0);
    foreach (mode_list[i]) begin
      apply_config(mode_list[i], 9'd4, 8'd2);
      send_beat(CMD_ADVANCE, 8'd5, 17'd0);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        mode = MODE_LOOP;
        frames = 9'd1;
        ticks = 8'd0;
      end else if (p == 1) begin
        mode = MODE_BLEND_PP_ONESHOT;
        frames = 9'd256;
        ticks = 8'd255;
      end else begin
        mode = MODE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 8));
        r = int'($urandom_range(0, 9));
        if (r < 6) frames = FRM_IN_W'($urandom_range(1, 12));
        else if (r < 9) frames = FRM_IN_W'($urandom_range(1, 256));
        else frames = FRM_IN_W'($urandom_range(0, 511));
        ticks = TICK_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 6)
                                                     : $urandom_range(0, 255));
      end
      apply_config(mode, frames, ticks);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        r = int'($urandom_range(0, 99));
        elapsed = ELAPSED_W'((r < 60) ? $urandom_range(0, 255) : $urandom_range(0, 4));
        if (r < 12) begin
          start = START_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                       : $urandom_range(0, 600));
          send_beat(CMD_RESTART, elapsed, start);
        end else begin
          start = START_W'($urandom_range(0, 131071));
          send_beat(CMD_ADVANCE, elapsed, start);
        end
      end
    end

    drain_results();
    repeat (70) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
